// ----- rtl/lwf_pkg.sv -----
// ----------------------------------------------------------------------------
// lwf_pkg
// Shared types and constants for the LCD window fill bus sequencer.
// ----------------------------------------------------------------------------
package lwf_pkg;

    // command codes
    localparam logic [2:0] CMD_FILL   = 3'd0;
    localparam logic [2:0] CMD_LINE   = 3'd1;
    localparam logic [2:0] CMD_PIXEL  = 3'd2;
    localparam logic [2:0] CMD_WINDOW = 3'd3;
    localparam logic [2:0] CMD_PUSH   = 3'd4;

    // configuration register indexes
    localparam logic [1:0] REG_TRANSPARENT_KEY = 2'd0;
    localparam logic [1:0] REG_SCREEN_WIDTH    = 2'd1;
    localparam logic [1:0] REG_SCREEN_HEIGHT   = 2'd2;

    localparam logic [31:0] TRANSPARENT_KEY_RST = 32'h0100_0000;
    localparam logic [14:0] SCREEN_WIDTH_RST    = 15'd320;
    localparam logic [14:0] SCREEN_HEIGHT_RST   = 15'd480;

    // display opcodes
    localparam logic [15:0] OP_COLADDR  = 16'h002a;
    localparam logic [15:0] OP_PAGEADDR = 16'h002b;
    localparam logic [15:0] OP_MEMWRITE = 16'h002c;
    localparam logic [15:0] BLACK       = 16'h0000;

    // word slots within one addressed transaction
    localparam logic [3:0] W_COL_OP  = 4'd0;
    localparam logic [3:0] W_XS_HI   = 4'd1;
    localparam logic [3:0] W_XS_LO   = 4'd2;
    localparam logic [3:0] W_XE_HI   = 4'd3;
    localparam logic [3:0] W_XE_LO   = 4'd4;
    localparam logic [3:0] W_PAGE_OP = 4'd5;
    localparam logic [3:0] W_YS_HI   = 4'd6;
    localparam logic [3:0] W_YS_LO   = 4'd7;
    localparam logic [3:0] W_YE_HI   = 4'd8;
    localparam logic [3:0] W_YE_LO   = 4'd9;
    localparam logic [3:0] W_MEM_WR  = 4'd10;
    localparam logic [3:0] W_COLOR   = 4'd11;

    // command queue
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        K_STATUS,   // status result only
        K_WINDOW,   // address words, last on memory write
        K_FILL,     // address words plus colour
        K_PUSH      // single data word
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic        status;
        logic [15:0] xa;
        logic [15:0] xb;
        logic [15:0] ya;
        logic [15:0] yb;
        logic [15:0] word;
        logic [16:0] w;
        logic [16:0] h;
    } t_desc;

endpackage

// ----- rtl/lcd_window_fill_bus_sequencer.sv -----
// ----------------------------------------------------------------------------
// lcd_window_fill_bus_sequencer
// Turns drawing commands into display-bus words with command/data flag,
// strobe count and last marker.
// ----------------------------------------------------------------------------
//   channel | signals                               | direction
//   --------+---------------------------------------+----------
//   in      | i_in_valid / o_in_ready, command data | to block
//   out     | o_out_valid / i_out_ready, bus word   | from block
//   cfg     | i_cfg_valid / o_cfg_ready, idx, data  | to block
//
// One result per cycle from the word sequencer while the output is not stalled:
// an addressed command gives 11 or 12 words, push pixel and status results one word each.
// Commands are classified on entry and wait in a 4-deep queue, so up to four
// more commands are taken while the output is stalled. Results only advance
// on i_out_ready.
// Reset is synchronous; config returns to its reset values, queue empties.
// ----------------------------------------------------------------------------
module lcd_window_fill_bus_sequencer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic        [2:0]  i_command,
    input  logic signed [15:0] i_x_start,
    input  logic signed [15:0] i_y_start,
    input  logic signed [15:0] i_x_end,
    input  logic signed [15:0] i_y_end,
    input  logic        [31:0] i_color,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_bus_valid,
    output logic               o_is_command,
    output logic        [15:0] o_bus_word,
    output logic        [32:0] o_repeat_count,
    output logic               o_status,
    output logic               o_last,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic        [1:0]  i_cfg_index,
    input  logic        [31:0] i_cfg_data
);
    import lwf_pkg::*;

    logic [31:0] r_transparent_key;
    logic [14:0] r_screen_width;
    logic [14:0] r_screen_height;

    t_desc front_desc;
    t_desc q_desc;
    logic  q_full, q_valid, q_pop;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_transparent_key <= TRANSPARENT_KEY_RST;
            r_screen_width    <= SCREEN_WIDTH_RST;
            r_screen_height   <= SCREEN_HEIGHT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_TRANSPARENT_KEY: r_transparent_key <= i_cfg_data;
                REG_SCREEN_WIDTH:    r_screen_width    <= i_cfg_data[14:0];
                REG_SCREEN_HEIGHT:   r_screen_height   <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    lwf_front u_front (
        .i_command         (i_command),
        .i_x_start         (i_x_start),
        .i_y_start         (i_y_start),
        .i_x_end           (i_x_end),
        .i_y_end           (i_y_end),
        .i_color           (i_color),
        .i_transparent_key (r_transparent_key),
        .i_screen_width    (r_screen_width),
        .i_screen_height   (r_screen_height),
        .o_desc            (front_desc)
    );

    lwf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in_valid),
        .i_desc  (front_desc),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_desc  (q_desc)
    );

    lwf_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_q_desc       (q_desc),
        .o_q_pop        (q_pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_bus_valid    (o_bus_valid),
        .o_is_command   (o_is_command),
        .o_bus_word     (o_bus_word),
        .o_repeat_count (o_repeat_count),
        .o_status       (o_status),
        .o_last         (o_last)
    );

endmodule

// ----- rtl/lwf_front.sv -----
// ----------------------------------------------------------------------------
// lwf_front
// Classifies one drawing command into a bus-word descriptor: orders corners,
// checks line bounds, resolves transparency.
// ----------------------------------------------------------------------------
module lwf_front (
    input  logic               [2:0]  i_command,
    input  logic signed        [15:0] i_x_start,
    input  logic signed        [15:0] i_y_start,
    input  logic signed        [15:0] i_x_end,
    input  logic signed        [15:0] i_y_end,
    input  logic               [31:0] i_color,
    input  logic               [31:0] i_transparent_key,
    input  logic               [14:0] i_screen_width,
    input  logic               [14:0] i_screen_height,
    output lwf_pkg::t_desc            o_desc
);
    import lwf_pkg::*;

    logic               transparent;
    logic signed [15:0] x_lo, x_hi, y_lo, y_hi;
    logic        [16:0] w_ord, h_ord;
    logic               in_bounds;
    logic               straight;

    assign transparent = (i_color == i_transparent_key);

    assign x_lo = (i_x_end < i_x_start) ? i_x_end : i_x_start;
    assign x_hi = (i_x_end < i_x_start) ? i_x_start : i_x_end;
    assign y_lo = (i_y_end < i_y_start) ? i_y_end : i_y_start;
    assign y_hi = (i_y_end < i_y_start) ? i_y_start : i_y_end;

    // span fits 17 bits: at most 65536
    assign w_ord = {x_hi[15], x_hi} - {x_lo[15], x_lo} + 17'd1;
    assign h_ord = {y_hi[15], y_hi} - {y_lo[15], y_lo} + 17'd1;

    assign in_bounds = !i_x_start[15] && (i_x_start[14:0] < i_screen_width)
                    && !i_y_start[15] && (i_y_start[14:0] < i_screen_height)
                    && !i_x_end[15]   && (i_x_end[14:0]   < i_screen_width)
                    && !i_y_end[15]   && (i_y_end[14:0]   < i_screen_height);
    assign straight  = (i_x_start == i_x_end) || (i_y_start == i_y_end);

    always_comb begin
        o_desc        = '0;
        o_desc.kind   = K_STATUS;
        o_desc.word   = i_color[15:0];
        o_desc.xa     = x_lo;
        o_desc.xb     = x_hi;
        o_desc.ya     = y_lo;
        o_desc.yb     = y_hi;
        o_desc.w      = w_ord;
        o_desc.h      = h_ord;
        unique case (i_command)
            CMD_FILL: begin
                if (!transparent) o_desc.kind = K_FILL;
            end
            CMD_LINE: begin
                if (!transparent) begin
                    if (in_bounds && straight) o_desc.kind = K_FILL;
                    else                       o_desc.status = 1'b1;
                end
            end
            CMD_PIXEL: begin
                if (!transparent) begin
                    o_desc.kind = K_FILL;
                    o_desc.xa   = i_x_start;
                    o_desc.xb   = i_x_start;
                    o_desc.ya   = i_y_start;
                    o_desc.yb   = i_y_start;
                    o_desc.w    = 17'd1;
                    o_desc.h    = 17'd1;
                end
            end
            CMD_WINDOW: begin
                // taken as given, not ordered
                o_desc.kind = K_WINDOW;
                o_desc.xa   = i_x_start;
                o_desc.xb   = i_x_end;
                o_desc.ya   = i_y_start;
                o_desc.yb   = i_y_end;
            end
            CMD_PUSH: begin
                o_desc.kind = K_PUSH;
                if (transparent) o_desc.word = BLACK;
            end
            default: begin
                o_desc.status = 1'b1;
            end
        endcase
    end

endmodule

// ----- rtl/lwf_queue.sv -----
// ----------------------------------------------------------------------------
// lwf_queue
// Short descriptor queue between the classifier and the word sequencer.
// ----------------------------------------------------------------------------
module lwf_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  lwf_pkg::t_desc i_desc,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output lwf_pkg::t_desc o_desc
);
    import lwf_pkg::*;

    t_desc               r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0]   r_count, n_count;
    logic                do_push, do_pop;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_desc  = r_mem[r_rd_ptr];

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = do_pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (do_push && !do_pop) n_count = r_count + 1'b1;
        if (!do_push && do_pop) n_count = r_count - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr_ptr] <= i_desc;
    end

endmodule

// ----- rtl/lwf_back.sv -----
// ----------------------------------------------------------------------------
// lwf_back
// Word sequencer: walks one descriptor slot by slot and drives the result
// register, one bus word per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module lwf_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  lwf_pkg::t_desc i_q_desc,
    output logic           o_q_pop,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic           o_bus_valid,
    output logic           o_is_command,
    output logic [15:0]    o_bus_word,
    output logic [32:0]    o_repeat_count,
    output logic           o_status,
    output logic           o_last
);
    import lwf_pkg::*;

    t_desc       r_desc;
    logic        r_busy;
    logic [3:0]  r_idx;
    logic [32:0] r_rep;
    logic [33:0] n_prod;

    logic        advance;
    logic        cur_last;
    logic        cur_bus, cur_cmd;
    logic [15:0] cur_word;
    logic [32:0] cur_rep;

    // strobe count is registered from the loaded descriptor in the cycle after load, well before the colour slot
    assign n_prod = 34'(r_desc.w) * 34'(r_desc.h);

    assign advance = !o_out_valid || i_out_ready;

    always_comb begin
        cur_bus  = 1'b1;
        cur_cmd  = 1'b0;
        cur_word = '0;
        cur_rep  = 33'd1;
        cur_last = 1'b0;
        unique case (r_idx)
            W_COL_OP:  begin cur_cmd = 1'b1; cur_word = OP_COLADDR; end
            W_XS_HI:   cur_word = {8'h00, r_desc.xa[15:8]};
            W_XS_LO:   cur_word = {8'h00, r_desc.xa[7:0]};
            W_XE_HI:   cur_word = {8'h00, r_desc.xb[15:8]};
            W_XE_LO:   cur_word = {8'h00, r_desc.xb[7:0]};
            W_PAGE_OP: begin cur_cmd = 1'b1; cur_word = OP_PAGEADDR; end
            W_YS_HI:   cur_word = {8'h00, r_desc.ya[15:8]};
            W_YS_LO:   cur_word = {8'h00, r_desc.ya[7:0]};
            W_YE_HI:   cur_word = {8'h00, r_desc.yb[15:8]};
            W_YE_LO:   cur_word = {8'h00, r_desc.yb[7:0]};
            W_MEM_WR:  begin
                cur_cmd  = 1'b1;
                cur_word = OP_MEMWRITE;
                cur_last = (r_desc.kind == K_WINDOW);
            end
            W_COLOR:   begin
                cur_word = r_desc.word;
                cur_rep  = r_rep;
                cur_last = 1'b1;
            end
            default:   cur_word = '0;
        endcase
        if (r_desc.kind == K_STATUS) begin
            cur_bus  = 1'b0;
            cur_cmd  = 1'b0;
            cur_word = '0;
            cur_rep  = 33'd1;
            cur_last = 1'b1;
        end else if (r_desc.kind == K_PUSH) begin
            cur_cmd  = 1'b0;
            cur_word = r_desc.word;
            cur_rep  = 33'd1;
            cur_last = 1'b1;
        end
    end

    // next descriptor loads in the cycle the current one sends its last word
    assign o_q_pop = i_q_valid && (!r_busy || (advance && cur_last));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (advance) o_out_valid <= r_busy;
            if (o_q_pop) begin
                r_busy <= 1'b1;
                r_idx  <= W_COL_OP;
            end else if (r_busy && advance) begin
                if (cur_last) r_busy <= 1'b0;
                else          r_idx  <= r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rep <= n_prod[32:0];
        if (o_q_pop) r_desc <= i_q_desc;
        if (advance) begin
            o_bus_valid    <= cur_bus;
            o_is_command   <= cur_cmd;
            o_bus_word     <= cur_word;
            o_repeat_count <= cur_rep;
            o_status       <= r_desc.status;
            o_last         <= cur_last;
        end
    end

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_idx <= W_COLOR)
        else $error("word slot past colour");

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_bus_valid |-> o_last)
        else $error("status result without last");

    a_bus_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_bus_valid |-> !o_status)
        else $error("bus word with fail status");

    a_repeat_colour: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_repeat_count != 33'd1 |-> o_bus_valid && !o_is_command && o_last)
        else $error("repeat count off colour word");

endmodule

// ----- dv/lwf_checker.sv -----
// ----------------------------------------------------------------------------
// lwf_checker
// Watches the command, result and register channels of the LCD window fill
// bus sequencer. It predicts the bus words of each accepted command and
// compares every accepted result, field by field, against the oldest
// prediction.
// ----------------------------------------------------------------------------
module lwf_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic        [2:0]  i_command,
    input  logic signed [15:0] i_x_start,
    input  logic signed [15:0] i_y_start,
    input  logic signed [15:0] i_x_end,
    input  logic signed [15:0] i_y_end,
    input  logic        [31:0] i_color,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic               i_bus_valid,
    input  logic               i_is_command,
    input  logic        [15:0] i_bus_word,
    input  logic        [32:0] i_repeat_count,
    input  logic               i_status,
    input  logic               i_last,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic        [1:0]  i_cfg_index,
    input  logic        [31:0] i_cfg_data,
    output int                 o_errors,
    output int                 o_pending,
    output int                 o_checked
);
    import lwf_pkg::*;

    typedef struct packed {
        logic        bus_valid;
        logic        is_command;
        logic [15:0] word;
        logic [32:0] repeat_count;
        logic        status;
        logic        last;
    } t_bus_result;

    t_bus_result expected_words[$];

    logic [31:0] key_q;
    logic [14:0] width_q;
    logic [14:0] height_q;
    int          mismatches = 0;
    int          checked = 0;

    function automatic void add_word(logic valid, logic cmd, logic [15:0] word,
                                     logic [32:0] rep, logic st);
        t_bus_result r;
        r.bus_valid    = valid;
        r.is_command   = cmd;
        r.word         = word;
        r.repeat_count = rep;
        r.status       = st;
        r.last         = 1'b0;
        expected_words.push_back(r);
    endfunction

    function automatic void mark_last();
        t_bus_result r;
        r = expected_words.pop_back();
        r.last = 1'b1;
        expected_words.push_back(r);
    endfunction

    function automatic void add_status(logic st);
        add_word(1'b0, 1'b0, 16'h0000, 33'd1, st);
        mark_last();
    endfunction

    // opcode, then start and end as high/low parameter bytes
    function automatic void add_address(logic [15:0] op, logic [15:0] a, logic [15:0] b);
        add_word(1'b1, 1'b1, op, 33'd1, 1'b0);
        add_word(1'b1, 1'b0, {8'h00, a[15:8]}, 33'd1, 1'b0);
        add_word(1'b1, 1'b0, {8'h00, a[7:0]}, 33'd1, 1'b0);
        add_word(1'b1, 1'b0, {8'h00, b[15:8]}, 33'd1, 1'b0);
        add_word(1'b1, 1'b0, {8'h00, b[7:0]}, 33'd1, 1'b0);
    endfunction

    function automatic void add_window(logic [15:0] xa, logic [15:0] ya,
                                       logic [15:0] xb, logic [15:0] yb);
        add_address(OP_COLADDR, xa, xb);
        add_address(OP_PAGEADDR, ya, yb);
        add_word(1'b1, 1'b1, OP_MEMWRITE, 33'd1, 1'b0);
    endfunction

    function automatic void add_fill(logic signed [15:0] x1, logic signed [15:0] y1,
                                     logic signed [15:0] x2, logic signed [15:0] y2,
                                     logic [31:0] color);
        logic signed [15:0] t;
        longint             w;
        longint             h;
        if (x2 < x1) begin
            t = x1; x1 = x2; x2 = t;
        end
        if (y2 < y1) begin
            t = y1; y1 = y2; y2 = t;
        end
        w = longint'(x2) - longint'(x1) + 1;
        h = longint'(y2) - longint'(y1) + 1;
        add_window(x1, y1, x2, y2);
        add_word(1'b1, 1'b0, color[15:0], 33'(w * h), 1'b0);
        mark_last();
    endfunction

    function automatic logic on_screen(logic signed [15:0] x, logic signed [15:0] y);
        return (int'(x) >= 0) && (int'(x) < int'(width_q)) &&
               (int'(y) >= 0) && (int'(y) < int'(height_q));
    endfunction

    function automatic void predict_bus_words(logic [2:0] cmd,
                                              logic signed [15:0] xs, logic signed [15:0] ys,
                                              logic signed [15:0] xe, logic signed [15:0] ye,
                                              logic [31:0] color);
        logic clear;
        clear = (color == key_q);
        case (cmd)
            CMD_FILL: begin
                if (clear) add_status(1'b0);
                else       add_fill(xs, ys, xe, ye, color);
            end
            CMD_LINE: begin
                if (clear)
                    add_status(1'b0);
                else if (!on_screen(xs, ys) || !on_screen(xe, ye))
                    add_status(1'b1);
                else if (xs != xe && ys != ye)
                    add_status(1'b1);
                else
                    add_fill(xs, ys, xe, ye, color);
            end
            CMD_PIXEL: begin
                if (clear) begin
                    add_status(1'b0);
                end else begin
                    add_window(xs, ys, xs, ys);
                    add_word(1'b1, 1'b0, color[15:0], 33'd1, 1'b0);
                    mark_last();
                end
            end
            CMD_WINDOW: begin
                add_window(xs, ys, xe, ye);
                mark_last();
            end
            CMD_PUSH: begin
                add_word(1'b1, 1'b0, clear ? BLACK : color[15:0], 33'd1, 1'b0);
                mark_last();
            end
            default: add_status(1'b1);
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_bus_result seen;
        t_bus_result want;
        if (!i_rst_n) begin
            key_q    = TRANSPARENT_KEY_RST;
            width_q  = SCREEN_WIDTH_RST;
            height_q = SCREEN_HEIGHT_RST;
            expected_words.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                seen = '{i_bus_valid, i_is_command, i_bus_word, i_repeat_count,
                         i_status, i_last};
                checked++;
                if (expected_words.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"[%0t] unexpected result: valid=%0b cmd=%0b word=%04h",
                                  " rep=%0d st=%0b last=%0b"},
                                 $realtime, seen.bus_valid, seen.is_command, seen.word,
                                 seen.repeat_count, seen.status, seen.last);
                end else begin
                    want = expected_words.pop_front();
                    if (seen !== want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("[%0t] result mismatch #%0d", $realtime, mismatches);
                            $display({"    expected: valid=%0b cmd=%0b word=%04h",
                                      " rep=%0d st=%0b last=%0b"},
                                     want.bus_valid, want.is_command, want.word,
                                     want.repeat_count, want.status, want.last);
                            $display({"    actual:   valid=%0b cmd=%0b word=%04h",
                                      " rep=%0d st=%0b last=%0b"},
                                     seen.bus_valid, seen.is_command, seen.word,
                                     seen.repeat_count, seen.status, seen.last);
                        end
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_TRANSPARENT_KEY: key_q    = i_cfg_data;
                    REG_SCREEN_WIDTH:    width_q  = i_cfg_data[14:0];
                    REG_SCREEN_HEIGHT:   height_q = i_cfg_data[14:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                predict_bus_words(i_command, i_x_start, i_y_start, i_x_end, i_y_end, i_color);
        end
        o_pending <= expected_words.size();
        o_errors  <= mismatches;
        o_checked <= checked;
    end

endmodule

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives drawing commands and register writes into the LCD window fill bus
// sequencer: a directed set of corner cases, then random commands under
// several screen and transparency settings, with random stalls on both sides.
// ----------------------------------------------------------------------------
module testbench;
    import lwf_pkg::*;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic        [2:0]  i_command = CMD_FILL;
    logic signed [15:0] i_x_start = '0;
    logic signed [15:0] i_y_start = '0;
    logic signed [15:0] i_x_end = '0;
    logic signed [15:0] i_y_end = '0;
    logic        [31:0] i_color = '0;
    logic               i_out_ready = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic        [1:0]  i_cfg_index = REG_TRANSPARENT_KEY;
    logic        [31:0] i_cfg_data = '0;

    logic               o_in_ready;
    logic               o_out_valid;
    logic               o_bus_valid;
    logic               o_is_command;
    logic        [15:0] o_bus_word;
    logic        [32:0] o_repeat_count;
    logic               o_status;
    logic               o_last;
    logic               o_cfg_ready;

    int errors;
    int pending;
    int checked;

    // stimulus-side copy of the settings, used only to shape commands
    logic [31:0] cur_key = TRANSPARENT_KEY_RST;
    logic [14:0] cur_w   = SCREEN_WIDTH_RST;
    logic [14:0] cur_h   = SCREEN_HEIGHT_RST;

    bit tx_idle = 1'b1;
    bit rx_idle = 1'b1;
    bit hold_req = 1'b0;
    bit hold_seen = 1'b0;
    int hold_left = 0;
    int n_cmds[8];
    int n_writes = 0;
    bit failed;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    lcd_window_fill_bus_sequencer u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_command      (i_command),
        .i_x_start      (i_x_start),
        .i_y_start      (i_y_start),
        .i_x_end        (i_x_end),
        .i_y_end        (i_y_end),
        .i_color        (i_color),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_bus_valid    (o_bus_valid),
        .o_is_command   (o_is_command),
        .o_bus_word     (o_bus_word),
        .o_repeat_count (o_repeat_count),
        .o_status       (o_status),
        .o_last         (o_last),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    lwf_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_command      (i_command),
        .i_x_start      (i_x_start),
        .i_y_start      (i_y_start),
        .i_x_end        (i_x_end),
        .i_y_end        (i_y_end),
        .i_color        (i_color),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_bus_valid    (o_bus_valid),
        .i_is_command   (o_is_command),
        .i_bus_word     (o_bus_word),
        .i_repeat_count (o_repeat_count),
        .i_status       (o_status),
        .i_last         (o_last),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_errors       (errors),
        .o_pending      (pending),
        .o_checked      (checked)
    );

    // result side: random stalls, plus a long hold-off each time hold_req toggles
    always @(posedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen   <= hold_req;
            hold_left   <= 400;
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= rx_idle ? ($urandom_range(99) >= 31) : 1'b1;
        end
    end

    task automatic send_cmd(input logic [2:0] cmd,
                            input logic signed [15:0] xs, input logic signed [15:0] ys,
                            input logic signed [15:0] xe, input logic signed [15:0] ye,
                            input logic [31:0] color);
        while (tx_idle && $urandom_range(99) < 31) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command  <= cmd;
        i_x_start  <= xs;
        i_y_start  <= ys;
        i_x_end    <= xe;
        i_y_end    <= ye;
        i_color    <= color;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        n_cmds[cmd]++;
    endtask

    // sender stops until every predicted bus word has come out
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        n_writes++;
    endtask

    task automatic write_config(input logic [31:0] key, input logic [14:0] w,
                                input logic [14:0] h);
        wait_drained();
        cfg_write(REG_TRANSPARENT_KEY, key);
        cfg_write(REG_SCREEN_WIDTH, {17'd0, w});
        cfg_write(REG_SCREEN_HEIGHT, {17'd0, h});
        i_cfg_valid <= 1'b0;
        cur_key = key;
        cur_w   = w;
        cur_h   = h;
    endtask

    function automatic logic signed [15:0] rand_coord();
        case ($urandom_range(3))
            0: return 16'($urandom);
            1: return 16'($urandom_range(63));
            2: return -16'sd1 - 16'($urandom_range(63));
            default: begin
                case ($urandom_range(3))
                    0: return 16'sh8000;
                    1: return 16'sh7fff;
                    2: return 16'sd0;
                    default: return -16'sd1;
                endcase
            end
        endcase
    endfunction

    task automatic send_random();
        int                 pick;
        logic [2:0]         cmd;
        logic signed [15:0] xs;
        logic signed [15:0] ys;
        logic signed [15:0] xe;
        logic signed [15:0] ye;
        logic [31:0]        color;
        pick = $urandom_range(99);
        if (pick < 20)      cmd = CMD_FILL;
        else if (pick < 50) cmd = CMD_LINE;
        else if (pick < 65) cmd = CMD_PIXEL;
        else if (pick < 80) cmd = CMD_WINDOW;
        else if (pick < 95) cmd = CMD_PUSH;
        else                cmd = CMD_PUSH + 3'($urandom_range(1, 3));
        color = ($urandom_range(99) < 20) ? cur_key : 32'($urandom);
        xs = rand_coord();
        ys = rand_coord();
        xe = rand_coord();
        ye = rand_coord();
        // lines mostly in bounds and axis aligned, some pushed just outside or made diagonal
        if (cmd == CMD_LINE && $urandom_range(99) < 85) begin
            xs = 16'($urandom_range(0, int'(cur_w) - 1));
            ys = 16'($urandom_range(0, int'(cur_h) - 1));
            if ($urandom_range(1)) begin
                xe = 16'($urandom_range(0, int'(cur_w) - 1));
                ye = ys;
            end else begin
                xe = xs;
                ye = 16'($urandom_range(0, int'(cur_h) - 1));
            end
            if ($urandom_range(99) < 20) begin
                case ($urandom_range(3))
                    0: xe = 16'(cur_w);
                    1: ys = 16'(cur_h);
                    2: xs = -16'sd1;
                    default: begin
                        xe = xs + 16'sd1;
                        ye = ys + 16'sd1;
                    end
                endcase
            end
        end
        send_cmd(cmd, xs, ys, xe, ye, color);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed corner cases at reset settings (320 x 480)
        send_cmd(CMD_FILL, 16'sd10, 16'sd20, 16'sd30, 16'sd40, 32'h0000_f800);
        send_cmd(CMD_FILL, 16'sd30, 16'sd40, 16'sd10, 16'sd20, 32'h1234_07e0);
        send_cmd(CMD_FILL, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 32'hffff_ffff);
        send_cmd(CMD_FILL, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 32'h0000_0000);
        send_cmd(CMD_FILL, 16'sd5, 16'sd5, 16'sd5, 16'sd5, 32'h00ff_001f);
        send_cmd(CMD_FILL, 16'sd1, 16'sd2, 16'sd3, 16'sd4, TRANSPARENT_KEY_RST);
        send_cmd(CMD_LINE, 16'sd0, 16'sd5, 16'sd319, 16'sd5, 32'h0000_abcd);
        send_cmd(CMD_LINE, 16'sd7, 16'sd479, 16'sd7, 16'sd0, 32'h0000_5555);
        send_cmd(CMD_LINE, 16'sd9, 16'sd9, 16'sd9, 16'sd9, 32'h0000_aaaa);
        send_cmd(CMD_LINE, 16'sd0, 16'sd0, 16'sd10, 16'sd10, 32'h0000_1111);
        send_cmd(CMD_LINE, 16'sd0, 16'sd0, 16'sd320, 16'sd0, 32'h0000_2222);
        send_cmd(CMD_LINE, 16'sd0, 16'sd480, 16'sd0, 16'sd0, 32'h0000_3333);
        send_cmd(CMD_LINE, -16'sd1, 16'sd3, 16'sd4, 16'sd3, 32'h0000_4444);
        send_cmd(CMD_LINE, 16'sh8000, 16'sh8000, 16'sd4, 16'sd7, TRANSPARENT_KEY_RST);
        send_cmd(CMD_PIXEL, 16'sd100, 16'sd200, 16'sd0, 16'sd0, 32'hdead_beef);
        send_cmd(CMD_PIXEL, 16'sh8000, -16'sd1, 16'sh7fff, 16'sd0, 32'h0000_ffff);
        send_cmd(CMD_PIXEL, 16'sd1, 16'sd1, 16'sd1, 16'sd1, TRANSPARENT_KEY_RST);
        send_cmd(CMD_WINDOW, 16'sd100, 16'sd200, 16'sd50, 16'sd10, 32'h0000_0001);
        send_cmd(CMD_WINDOW, 16'sh7fff, 16'sh8000, -16'sd1, 16'sh0100, TRANSPARENT_KEY_RST);
        send_cmd(CMD_PUSH, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'hffff_ffff);
        send_cmd(CMD_PUSH, 16'sd0, 16'sd0, 16'sd0, 16'sd0, TRANSPARENT_KEY_RST);
        send_cmd(CMD_PUSH, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'h0000_0000);
        send_cmd(CMD_PUSH + 3'd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'h0000_0000);
        send_cmd(CMD_PUSH + 3'd2, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 32'h0);
        send_cmd(CMD_PUSH + 3'd3, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 32'h0);

        // smallest screen, black is the transparent colour
        write_config(32'h0000_0000, 15'd1, 15'd1);
        repeat (30) send_random();

        // largest screen and key, no idling on either side
        write_config(32'hffff_ffff, 15'd32767, 15'd32767);
        tx_idle = 1'b0;
        rx_idle <= 1'b0;
        repeat (40) send_random();

        // result side holds off while commands keep coming
        tx_idle = 1'b1;
        rx_idle <= 1'b1;
        write_config(32'($urandom), 15'($urandom_range(1, 640)), 15'($urandom_range(1, 640)));
        hold_req <= ~hold_req;
        repeat (20) send_random();
        wait_drained();
        repeat (40) send_random();

        write_config(32'h0000_ffff, 15'($urandom_range(1, 32767)),
                     15'($urandom_range(1, 32767)));
        repeat (50) send_random();

        wait_drained();
        repeat (50) @(posedge i_clk);
        failed = (errors != 0) || (pending != 0);
        $display({"Coverage: %0d commands (fill %0d, line %0d, pixel %0d, window %0d,",
                  " push %0d, undefined %0d), %0d register writes"},
                 n_cmds.sum(), n_cmds[CMD_FILL], n_cmds[CMD_LINE], n_cmds[CMD_PIXEL],
                 n_cmds[CMD_WINDOW], n_cmds[CMD_PUSH],
                 n_cmds[5] + n_cmds[6] + n_cmds[7], n_writes);
        $display("Coverage: %0d bus results compared, %0d mismatches, %0d outstanding",
                 checked, errors, pending);
        if (!failed)
            $display("** lcd_window_fill_bus_sequencer: PASSED **");
        else
            $display("** lcd_window_fill_bus_sequencer: FAILED **");
        $finish;
    end

    initial begin
        #2000000;
        $display("Timeout waiting for the sequencer to finish");
        $display("** lcd_window_fill_bus_sequencer: FAILED **");
        $finish;
    end

endmodule
